@@ hw/rtl/sphc_pkg.sv @@
`timescale 1ns / 1ps

package sphc_pkg;

	localparam int STEP_W       = 24;
	localparam int RETRACT_W    = STEP_W - 1;
	localparam int TIMEOUT_W    = 20;
	localparam int HALF_W       = 17;
	localparam int SETUP_W      = 10;
	localparam int TICKS_PER_MS = 1000;
	localparam int CFG_ADDR_W   = 5;
	localparam int CFG_DATA_W   = 32;

	localparam logic [HALF_W-1:0] HALF_MIN = HALF_W'(50);
	localparam logic [HALF_W-1:0] HALF_MAX = HALF_W'(100000);

	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_MOVE   = 3'd1;
	localparam logic [2:0] MODE_HOME   = 3'd2;
	localparam logic [2:0] MODE_STOP   = 3'd3;
	localparam logic [2:0] MODE_ENABLE = 3'd4;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_MOVE_DONE = 3'd1;
	localparam logic [2:0] EV_HOME_DONE = 3'd2;
	localparam logic [2:0] EV_ABORT     = 3'd3;
	localparam logic [2:0] EV_REFUSED   = 3'd4;

	localparam logic [1:0] ABORT_NONE    = 2'd0;
	localparam logic [1:0] ABORT_TIMEOUT = 2'd1;
	localparam logic [1:0] ABORT_STOP    = 2'd2;
	localparam logic [1:0] ABORT_ENDSTOP = 2'd3;

	localparam logic [2:0] REG_STEP_HALF = 3'd0;
	localparam logic [2:0] REG_HOME_HALF = 3'd1;
	localparam logic [2:0] REG_MAX_MS    = 3'd2;
	localparam logic [2:0] REG_DIR_SETUP = 3'd3;
	localparam logic [2:0] REG_INVERT    = 3'd4;
	localparam logic [2:0] REG_HOME_NEG  = 3'd5;
	localparam logic [2:0] REG_AUTO_DIS  = 3'd6;
	localparam logic [2:0] REG_HOME_EN   = 3'd7;

	typedef struct packed {
		logic [HALF_W-1:0]    step_half;
		logic [HALF_W-1:0]    home_half;
		logic [TIMEOUT_W-1:0] max_move_ms;
		logic [SETUP_W-1:0]   dir_setup;
		logic                 invert_dir;
		logic                 home_neg;
		logic                 auto_disable;
		logic                 homing_en;
	} cfg_t;

	typedef struct packed {
		logic [2:0]               mode;
		logic signed [STEP_W-1:0] move_steps;
		logic [RETRACT_W-1:0]     retract_steps;
		logic                     endstop;
	} cmd_t;

	typedef struct packed {
		logic                 step_out;
		logic                 dir_out;
		logic                 enable_out;
		logic                 busy_res;
		logic [2:0]           event_res;
		logic [1:0]           abort_reason;
		logic [RETRACT_W-1:0] completed_steps;
	} res_t;

endpackage

@@ hw/rtl/sphc_regs.sv @@
`timescale 1ns / 1ps

module sphc_regs
	import sphc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_half    <= HALF_W'(1000);
			cfg_q.home_half    <= HALF_W'(1000);
			cfg_q.max_move_ms  <= TIMEOUT_W'(60000);
			cfg_q.dir_setup    <= SETUP_W'(20);
			cfg_q.invert_dir   <= 1'b0;
			cfg_q.home_neg     <= 1'b1;
			cfg_q.auto_disable <= 1'b1;
			cfg_q.homing_en    <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				REG_STEP_HALF: cfg_q.step_half    <= pwdata[HALF_W-1:0];
				REG_HOME_HALF: cfg_q.home_half    <= pwdata[HALF_W-1:0];
				REG_MAX_MS:    cfg_q.max_move_ms  <= pwdata[TIMEOUT_W-1:0];
				REG_DIR_SETUP: cfg_q.dir_setup    <= pwdata[SETUP_W-1:0];
				REG_INVERT:    cfg_q.invert_dir   <= pwdata[0];
				REG_HOME_NEG:  cfg_q.home_neg     <= pwdata[0];
				REG_AUTO_DIS:  cfg_q.auto_disable <= pwdata[0];
				REG_HOME_EN:   cfg_q.homing_en    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_STEP_HALF: prdata = CFG_DATA_W'(cfg_q.step_half);
			REG_HOME_HALF: prdata = CFG_DATA_W'(cfg_q.home_half);
			REG_MAX_MS:    prdata = CFG_DATA_W'(cfg_q.max_move_ms);
			REG_DIR_SETUP: prdata = CFG_DATA_W'(cfg_q.dir_setup);
			REG_INVERT:    prdata = CFG_DATA_W'(cfg_q.invert_dir);
			REG_HOME_NEG:  prdata = CFG_DATA_W'(cfg_q.home_neg);
			REG_AUTO_DIS:  prdata = CFG_DATA_W'(cfg_q.auto_disable);
			REG_HOME_EN:   prdata = CFG_DATA_W'(cfg_q.homing_en);
			default:       prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/sphc_core.sv @@
`timescale 1ns / 1ps

module sphc_core
	import sphc_pkg::*;
#(
	parameter int TICKS = TICKS_PER_MS
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic fire,
	input  cmd_t item,
	output res_t result
);

	localparam int PRE_W = (TICKS > 1) ? $clog2(TICKS) : 1;
	localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(TICKS - 1);

	typedef enum logic [1:0] {PH_NORMAL, PH_SEEK, PH_RETRACT} phase_t;

	typedef struct packed {
		logic                 active;
		logic                 step;
		logic                 fwd;
		logic                 bounded;
		phase_t               phase;
		logic [STEP_W-1:0]    target;
		logic [STEP_W-1:0]    done;
		logic [HALF_W-1:0]    cd;
		logic [HALF_W-1:0]    half;
		logic [PRE_W-1:0]     pre;
		logic [TIMEOUT_W-1:0] elapsed;
		logic [RETRACT_W-1:0] retract;
	} mot_t;

	function automatic mot_t motion_idle();
		mot_t m;
		m         = '0;
		m.fwd     = 1'b1;
		m.bounded = 1'b1;
		m.phase   = PH_NORMAL;
		return m;
	endfunction

	function automatic logic [HALF_W-1:0] clamp_half(input logic [HALF_W-1:0] v);
		logic [HALF_W-1:0] r;
		r = v;
		if (v < HALF_MIN) r = HALF_MIN;
		else if (v > HALF_MAX) r = HALF_MAX;
		return r;
	endfunction

	function automatic mot_t motion_start(input logic fwd, input logic [STEP_W-1:0] total,
			input logic bounded, input logic [HALF_W-1:0] half, input phase_t ph,
			input logic [SETUP_W-1:0] setup);
		mot_t m;
		m         = motion_idle();
		m.active  = 1'b1;
		m.fwd     = fwd;
		m.bounded = bounded;
		m.target  = total;
		m.half    = clamp_half(half);
		m.phase   = ph;
		m.cd      = HALF_W'(setup);
		return m;
	endfunction

	mot_t                 mot_q, mot_n;
	logic                 dir_q, dir_n;
	logic                 en_q, en_n;
	logic [1:0]           abort_q, abort_n;
	logic [2:0]           ev;
	logic                 ended;
	logic                 fin, fin_abort;
	logic [1:0]           fin_reason;
	logic [STEP_W-1:0]    end_cnt;
	logic [STEP_W-1:0]    done_inc;
	logic [STEP_W-1:0]    raw;
	logic [STEP_W-1:0]    mag;
	logic                 neg;
	logic [HALF_W-1:0]    cd_dec;
	logic [TIMEOUT_W-1:0] elapsed_nx;
	logic                 trig;

	assign raw      = item.move_steps;
	assign neg      = raw[STEP_W-1];
	assign mag      = neg ? (~raw + STEP_W'(1)) : raw;
	assign done_inc = (mot_q.done != '1) ? (mot_q.done + STEP_W'(1)) : mot_q.done;
	assign cd_dec   = (mot_q.cd != '0) ? (mot_q.cd - HALF_W'(1)) : mot_q.cd;
	assign trig     = item.endstop && (mot_q.phase != PH_RETRACT) && !mot_q.fwd;

	always_comb begin
		elapsed_nx = mot_q.elapsed;
		if (mot_q.pre == PRE_LAST && mot_q.elapsed != '1) begin
			elapsed_nx = mot_q.elapsed + TIMEOUT_W'(1);
		end
	end

	always_comb begin
		mot_n      = mot_q;
		dir_n      = dir_q;
		en_n       = en_q;
		abort_n    = abort_q;
		ev         = EV_NONE;
		ended      = 1'b0;
		fin        = 1'b0;
		fin_abort  = 1'b0;
		fin_reason = ABORT_NONE;
		end_cnt    = mot_q.done;
		case (item.mode)
			MODE_TICK: begin
				if (mot_q.active) begin
					mot_n.pre     = (mot_q.pre == PRE_LAST) ? '0 : mot_q.pre + PRE_W'(1);
					mot_n.elapsed = elapsed_nx;
					if (trig) begin
						if (mot_q.phase == PH_SEEK) begin
							if (mot_q.retract == '0) begin
								mot_n   = motion_idle();
								en_n    = 1'b0;
								abort_n = ABORT_NONE;
								ev      = EV_HOME_DONE;
								ended   = 1'b1;
							end else begin
								mot_n = motion_start(cfg.home_neg, STEP_W'(mot_q.retract),
									1'b1, cfg.home_half, PH_RETRACT, cfg.dir_setup);
								dir_n   = cfg.invert_dir ^ cfg.home_neg;
								en_n    = 1'b1;
								abort_n = ABORT_NONE;
							end
						end else begin
							fin        = 1'b1;
							fin_abort  = 1'b1;
							fin_reason = ABORT_ENDSTOP;
						end
					end else if (elapsed_nx >= cfg.max_move_ms) begin
						fin        = 1'b1;
						fin_abort  = 1'b1;
						fin_reason = ABORT_TIMEOUT;
					end else if (cd_dec != '0) begin
						mot_n.cd = cd_dec;
					end else if (!mot_q.step) begin
						mot_n.step = 1'b1;
						mot_n.cd   = mot_q.half;
					end else if (mot_q.bounded && done_inc >= mot_q.target) begin
						fin     = 1'b1;
						end_cnt = done_inc;
					end else begin
						mot_n.step = 1'b0;
						mot_n.done = done_inc;
						mot_n.cd   = mot_q.half;
					end
				end
			end
			MODE_MOVE: begin
				if (raw != '0) begin
					if (mot_q.active) begin
						ev = EV_REFUSED;
					end else if (item.endstop && neg) begin
						abort_n = ABORT_ENDSTOP;
						ev      = EV_REFUSED;
					end else begin
						mot_n = motion_start(!neg, mag, 1'b1, cfg.step_half, PH_NORMAL,
							cfg.dir_setup);
						dir_n   = cfg.invert_dir ^ !neg;
						en_n    = 1'b1;
						abort_n = ABORT_NONE;
					end
				end
			end
			MODE_HOME: begin
				if (!cfg.homing_en) begin
					ev = EV_REFUSED;
				end else if (item.endstop) begin
					abort_n = ABORT_ENDSTOP;
					ev      = EV_REFUSED;
				end else if (mot_q.active) begin
					ev = EV_REFUSED;
				end else begin
					mot_n = motion_start(!cfg.home_neg, '0, 1'b0, cfg.home_half, PH_SEEK,
						cfg.dir_setup);
					mot_n.retract = item.retract_steps;
					dir_n   = cfg.invert_dir ^ !cfg.home_neg;
					en_n    = 1'b1;
					abort_n = ABORT_NONE;
				end
			end
			MODE_STOP: begin
				if (mot_q.active) begin
					fin        = 1'b1;
					fin_abort  = 1'b1;
					fin_reason = ABORT_STOP;
				end else begin
					en_n = 1'b0;
				end
			end
			MODE_ENABLE: begin
				if (!mot_q.active) en_n = 1'b1;
			end
			default: ;
		endcase
		if (fin) begin
			mot_n   = motion_idle();
			abort_n = fin_abort ? fin_reason : ABORT_NONE;
			ended   = 1'b1;
			if (mot_q.phase != PH_NORMAL || cfg.auto_disable || fin_abort) en_n = 1'b0;
			if (fin_abort) ev = EV_ABORT;
			else if (mot_q.phase == PH_RETRACT) ev = EV_HOME_DONE;
			else ev = EV_MOVE_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mot_q   <= motion_idle();
			dir_q   <= 1'b0;
			en_q    <= 1'b0;
			abort_q <= ABORT_NONE;
		end else if (fire) begin
			mot_q   <= mot_n;
			dir_q   <= dir_n;
			en_q    <= en_n;
			abort_q <= abort_n;
		end
	end

	assign result.step_out        = mot_n.step;
	assign result.dir_out         = dir_n;
	assign result.enable_out      = en_n;
	assign result.busy_res        = mot_n.active;
	assign result.event_res       = ev;
	assign result.abort_reason    = abort_n;
	assign result.completed_steps = ended ? end_cnt[RETRACT_W-1:0] : mot_n.done[RETRACT_W-1:0];

endmodule

@@ hw/rtl/stepper_pulse_homing_controller.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// cmd       in         cmd_valid/cmd_stall  cmd_t: mode, move_steps, retract_steps, endstop
// res       out        res_valid/res_stall  res_t: pins, busy, event, abort, completed steps
// apb       in/out     psel/penable/pready  eight configuration registers at 4*i
//
// Every command item yields one result item via the input and output registers.
// One item is taken per cycle while cmd_stall is low; motion state is registered per item.
// A stalled result holds in the output register while one more item waits
// in the input register; cmd_stall rises only when both are full.
// Reset restores the register defaults and leaves the axis idle and disabled.

module stepper_pulse_homing_controller
	import sphc_pkg::*;
#(
	parameter int TICKS_PER_MS_P = TICKS_PER_MS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_t                  cmd,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_t                  res
);

	cfg_t cfg;
	cmd_t cmd_s1;
	logic valid_s1;
	res_t res_d;
	res_t res_q;
	logic res_valid_q;
	logic adv;
	logic fire;
	logic take;

	assign adv       = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && adv;
	assign cmd_stall = valid_s1 && !adv;
	assign take      = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	sphc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sphc_core #(
		.TICKS (TICKS_PER_MS_P)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (cmd_s1),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (fire) valid_s1 <= 1'b0;
			if (fire) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) cmd_s1 <= cmd;
		if (fire) res_q <= res_d;
	end

`ifndef NO_ASSERTIONS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && res_valid_q))
		else $error("command stalled while a stage was free");

	a_idle_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.busy_res) |-> !res.step_out)
		else $error("step pin high with no motion active");

	a_busy_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.busy_res) |-> res.enable_out)
		else $error("driver disabled during a motion");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.event_res == EV_MOVE_DONE || res.event_res == EV_HOME_DONE
			|| res.event_res == EV_ABORT)) |-> !res.busy_res)
		else $error("motion still active after it ended");
`endif

endmodule

@@ sim/stepper_pulse_homing_controller_check.sv @@
`timescale 1ns / 1ps

module stepper_pulse_homing_controller_check
	import sphc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	input  logic [CFG_DATA_W-1:0] prdata,
	input  logic                  pready,
	input  logic                  cmd_valid,
	input  logic                  cmd_stall,
	input  cmd_t                  cmd,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  res_t                  res,
	output int                    mismatches,
	output int                    outstanding
);

	typedef enum logic [1:0] {PH_NORMAL, PH_SEEK, PH_RETRACT} phase_t;

	cfg_t                 cfg;
	logic                 moving, step_lvl, fwd, dir_lvl, en_lvl, bounded;
	phase_t               phase;
	logic [STEP_W-1:0]    target, done_cnt, retract_plan, end_cnt;
	logic [HALF_W-1:0]    countdown, half;
	int unsigned          prescale;
	logic [TIMEOUT_W-1:0] elapsed;
	logic [1:0]           last_abort;
	res_t                 due_results[$];
	res_t                 want;
	logic [31:0]          reg_now;
	int                   err_count;

	function automatic void field_check(input string what, input logic [31:0] expv,
			input logic [31:0] got);
		if (expv !== got) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, what, expv, got);
			err_count++;
		end
	endfunction

	function automatic void motion_clear();
		moving = 1'b0;
		step_lvl = 1'b0;
		fwd = 1'b1;
		bounded = 1'b1;
		phase = PH_NORMAL;
		target = '0;
		done_cnt = '0;
		countdown = '0;
		half = '0;
		prescale = 0;
		elapsed = '0;
		retract_plan = '0;
	endfunction

	function automatic void motion_begin(input logic f, input logic [STEP_W-1:0] total,
			input logic bnd, input logic [HALF_W-1:0] hp, input phase_t ph);
		motion_clear();
		moving = 1'b1;
		fwd = f;
		dir_lvl = cfg.invert_dir ? !f : f;
		bounded = bnd;
		target = total;
		half = (hp < HALF_MIN) ? HALF_MIN : (hp > HALF_MAX) ? HALF_MAX : hp;
		phase = ph;
		en_lvl = 1'b1;
		countdown = HALF_W'(cfg.dir_setup);
		last_abort = ABORT_NONE;
	endfunction

	function automatic logic [2:0] motion_finish(input logic aborted, input logic [1:0] why);
		phase_t ph;
		logic   drop;
		ph = phase;
		end_cnt = done_cnt;
		last_abort = aborted ? why : ABORT_NONE;
		motion_clear();
		drop = (ph == PH_NORMAL) ? (cfg.auto_disable || aborted) : 1'b1;
		if (drop)
			en_lvl = 1'b0;
		if (aborted)
			return EV_ABORT;
		return (ph == PH_RETRACT) ? EV_HOME_DONE : EV_MOVE_DONE;
	endfunction

	function automatic logic [2:0] tick_apply(input logic es);
		logic [STEP_W-1:0] back;
		if (!moving)
			return EV_NONE;
		prescale++;
		if (prescale >= TICKS_PER_MS) begin
			prescale = 0;
			if (elapsed != '1)
				elapsed++;
		end
		if (es && phase != PH_RETRACT && !fwd) begin
			if (phase == PH_SEEK) begin
				back = retract_plan;
				end_cnt = done_cnt;
				motion_clear();
				if (back == '0) begin
					en_lvl = 1'b0;
					last_abort = ABORT_NONE;
					return EV_HOME_DONE;
				end
				motion_begin(cfg.home_neg, back, 1'b1, cfg.home_half, PH_RETRACT);
				return EV_NONE;
			end
			return motion_finish(1'b1, ABORT_ENDSTOP);
		end
		if (elapsed >= cfg.max_move_ms)
			return motion_finish(1'b1, ABORT_TIMEOUT);
		if (countdown != '0)
			countdown--;
		if (countdown != '0)
			return EV_NONE;
		if (!step_lvl) begin
			step_lvl = 1'b1;
			countdown = half;
			return EV_NONE;
		end
		step_lvl = 1'b0;
		if (done_cnt != '1)
			done_cnt++;
		if (bounded && done_cnt >= target)
			return motion_finish(1'b0, ABORT_NONE);
		countdown = half;
		return EV_NONE;
	endfunction

	function automatic res_t axis_apply(input cmd_t c);
		res_t              r;
		logic [2:0]        ev;
		logic              ended, was, neg;
		logic [STEP_W-1:0] raw, mag;
		ev = EV_NONE;
		ended = 1'b0;
		raw = c.move_steps;
		case (c.mode)
			MODE_TICK: begin
				was = moving;
				ev = tick_apply(c.endstop);
				ended = was && ev != EV_NONE;
			end
			MODE_MOVE: begin
				if (raw != '0) begin
					neg = raw[STEP_W-1];
					mag = neg ? -raw : raw;
					if (moving) begin
						ev = EV_REFUSED;
					end else if (c.endstop && neg) begin
						last_abort = ABORT_ENDSTOP;
						ev = EV_REFUSED;
					end else begin
						motion_begin(!neg, mag, 1'b1, cfg.step_half, PH_NORMAL);
					end
				end
			end
			MODE_HOME: begin
				if (!cfg.homing_en) begin
					ev = EV_REFUSED;
				end else if (c.endstop) begin
					last_abort = ABORT_ENDSTOP;
					ev = EV_REFUSED;
				end else if (moving) begin
					ev = EV_REFUSED;
				end else begin
					motion_begin(!cfg.home_neg, '0, 1'b0, cfg.home_half, PH_SEEK);
					retract_plan = STEP_W'(c.retract_steps);
				end
			end
			MODE_STOP: begin
				if (moving) begin
					ev = motion_finish(1'b1, ABORT_STOP);
					ended = 1'b1;
				end else begin
					en_lvl = 1'b0;
				end
			end
			MODE_ENABLE: begin
				if (!moving)
					en_lvl = 1'b1;
			end
			default: begin
			end
		endcase
		r.step_out = step_lvl;
		r.dir_out = dir_lvl;
		r.enable_out = en_lvl;
		r.busy_res = moving;
		r.event_res = ev;
		r.abort_reason = last_abort;
		r.completed_steps = ended ? end_cnt[RETRACT_W-1:0] : done_cnt[RETRACT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.step_half = HALF_W'(1000);
			cfg.home_half = HALF_W'(1000);
			cfg.max_move_ms = TIMEOUT_W'(60000);
			cfg.dir_setup = SETUP_W'(20);
			cfg.invert_dir = 1'b0;
			cfg.home_neg = 1'b1;
			cfg.auto_disable = 1'b1;
			cfg.homing_en = 1'b1;
			motion_clear();
			dir_lvl = 1'b0;
			en_lvl = 1'b0;
			last_abort = ABORT_NONE;
			end_cnt = '0;
			due_results.delete();
			err_count = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[4:2])
						REG_STEP_HALF: cfg.step_half = pwdata[HALF_W-1:0];
						REG_HOME_HALF: cfg.home_half = pwdata[HALF_W-1:0];
						REG_MAX_MS:    cfg.max_move_ms = pwdata[TIMEOUT_W-1:0];
						REG_DIR_SETUP: cfg.dir_setup = pwdata[SETUP_W-1:0];
						REG_INVERT:    cfg.invert_dir = pwdata[0];
						REG_HOME_NEG:  cfg.home_neg = pwdata[0];
						REG_AUTO_DIS:  cfg.auto_disable = pwdata[0];
						default:       cfg.homing_en = pwdata[0];
					endcase
				end else begin
					case (paddr[4:2])
						REG_STEP_HALF: reg_now = 32'(cfg.step_half);
						REG_HOME_HALF: reg_now = 32'(cfg.home_half);
						REG_MAX_MS:    reg_now = 32'(cfg.max_move_ms);
						REG_DIR_SETUP: reg_now = 32'(cfg.dir_setup);
						REG_INVERT:    reg_now = 32'(cfg.invert_dir);
						REG_HOME_NEG:  reg_now = 32'(cfg.home_neg);
						REG_AUTO_DIS:  reg_now = 32'(cfg.auto_disable);
						default:       reg_now = 32'(cfg.homing_en);
					endcase
					field_check("register read", reg_now, prdata);
				end
			end
			if (cmd_valid && !cmd_stall)
				due_results.push_back(axis_apply(cmd));
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t result with nothing expected: expected none, actual %h",
						$time, res);
					err_count++;
				end else begin
					want = due_results.pop_front();
					field_check("step_out", 32'(want.step_out), 32'(res.step_out));
					field_check("dir_out", 32'(want.dir_out), 32'(res.dir_out));
					field_check("enable_out", 32'(want.enable_out), 32'(res.enable_out));
					field_check("busy_res", 32'(want.busy_res), 32'(res.busy_res));
					field_check("event_res", 32'(want.event_res), 32'(res.event_res));
					field_check("abort_reason", 32'(want.abort_reason),
						32'(res.abort_reason));
					field_check("completed_steps", 32'(want.completed_steps),
						32'(res.completed_steps));
				end
			end
		end
		mismatches <= err_count;
		outstanding <= due_results.size();
	end

endmodule

@@ sim/stepper_pulse_homing_controller_tb.sv @@
`timescale 1ns / 1ps

module stepper_pulse_homing_controller_tb;
	import sphc_pkg::*;

	localparam int ITEMS_TOTAL  = 1300;
	localparam int PHASES       = 8;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int NO_TRIGGER   = 32'h3FFF_FFFF;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr     = '0;
	logic [CFG_DATA_W-1:0] pwdata    = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	cmd_t                  cmd       = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;
	int                    mismatches;
	int                    outstanding;

	int   sent_items     = 0;
	int   cycles         = 0;
	logic tx_calm        = 1'b0;
	int   res_seen       = 0;
	int   stall_left     = 0;
	int   calm_left      = 0;
	int   rx_pick        = 0;
	logic rx_calm        = 1'b0;
	logic long_hold_done = 1'b0;

	stepper_pulse_homing_controller i_dut (.*);

	stepper_pulse_homing_controller_check i_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (res_valid && !res_stall)
			res_seen++;
		if (calm_left == 0) begin
			calm_left = $urandom_range(60, 240);
			rx_calm = ($urandom_range(0, 3) == 0);
		end else begin
			calm_left--;
		end
		if (stall_left != 0) begin
			stall_left--;
		end else if (!long_hold_done && res_seen >= 300) begin
			long_hold_done = 1'b1;
			stall_left = 250;
		end else if (!rx_calm) begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 15)
				stall_left = $urandom_range(1, 3);
			else if (rx_pick < 18)
				stall_left = $urandom_range(10, 40);
		end
		res_stall <= (stall_left != 0);
	end

	function automatic cmd_t command(input logic [2:0] mode, input int steps,
			input int unsigned back, input logic es);
		cmd_t c;
		c.mode = mode;
		c.move_steps = steps[STEP_W-1:0];
		c.retract_steps = back[RETRACT_W-1:0];
		c.endstop = es;
		return c;
	endfunction

	task automatic send(input cmd_t item);
		int gap;
		gap = 0;
		if (!tx_calm) begin
			gap = $urandom_range(0, 99);
			gap = (gap < 50) ? 0 : (gap < 88) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		end
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		do @(posedge clk); while (cmd_stall);
		sent_items++;
	endtask

	task automatic tick_run(input int n, input int es_from);
		for (int k = 0; k < n; k++)
			send(command(MODE_TICK, $urandom, $urandom, k >= es_from));
	endtask

	task automatic drain(input int extra);
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic reg_readback();
		for (int i = 0; i < 8; i++)
			apb_access(1'b0, 3'(i), $urandom);
	endtask

	task automatic set_config(input int unsigned sh, input int unsigned hh, input int unsigned mx,
			input int unsigned su, input int unsigned inv, input int unsigned neg,
			input int unsigned ad, input int unsigned hen);
		send(command(MODE_STOP, $urandom, $urandom, 1'($urandom)));
		drain(4);
		reg_readback();
		apb_access(1'b1, REG_STEP_HALF, ($urandom << HALF_W) | sh);
		apb_access(1'b1, REG_HOME_HALF, ($urandom << HALF_W) | hh);
		apb_access(1'b1, REG_MAX_MS, ($urandom << TIMEOUT_W) | mx);
		apb_access(1'b1, REG_DIR_SETUP, ($urandom << SETUP_W) | su);
		apb_access(1'b1, REG_INVERT, ($urandom << 1) | inv);
		apb_access(1'b1, REG_HOME_NEG, ($urandom << 1) | neg);
		apb_access(1'b1, REG_AUTO_DIS, ($urandom << 1) | ad);
		apb_access(1'b1, REG_HOME_EN, ($urandom << 1) | hen);
		reg_readback();
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic scenario();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				n = $urandom_range(1, 3);
				if ($urandom_range(0, 1))
					n = -n;
				send(command(MODE_MOVE, n, $urandom, $urandom_range(0, 3) == 0));
			end else if (pick < 8) begin
				send(command(MODE_HOME, $urandom,
					($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2),
					$urandom_range(0, 7) == 0));
			end else if (pick == 8) begin
				send(command(MODE_ENABLE, $urandom, $urandom, 1'($urandom)));
			end else begin
				send(command(MODE_STOP, $urandom, $urandom, 1'($urandom)));
			end
			n = $urandom_range(20, 260);
			tick_run(n, $urandom_range(0, 3 * n));
			if ($urandom_range(0, 2) == 0)
				send(command(MODE_STOP, $urandom, $urandom, 1'($urandom)));
		end else begin
			repeat ($urandom_range(1, 4))
				send(command(3'($urandom), $urandom, $urandom, 1'($urandom)));
		end
		tx_calm = ($urandom_range(0, 3) == 0);
	endtask

	initial begin
		int goal;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(0, 49, 20'hFFFFF, 0, 0, 1, 1, 1);
		send(command(MODE_TICK, 0, 0, 1'b1));
		for (int k = 1; k <= 3; k++)
			send(command(3'(MODE_ENABLE + k), $urandom, $urandom, k[0]));
		send(command(MODE_ENABLE, 0, 0, 1'b0));
		send(command(MODE_STOP, 0, 0, 1'b0));
		send(command(MODE_MOVE, 0, 0, 1'b1));
		send(command(MODE_MOVE, -1, 0, 1'b1));
		send(command(MODE_MOVE, 1, 0, 1'b1));
		send(command(MODE_MOVE, 5, 0, 1'b0));
		send(command(MODE_HOME, 0, 0, 1'b0));
		send(command(MODE_ENABLE, 0, 0, 1'b0));
		tick_run(60, NO_TRIGGER);
		send(command(MODE_MOVE, -8388607, 0, 1'b0));
		tick_run(5, NO_TRIGGER);
		send(command(MODE_STOP, 0, 0, 1'b0));
		send(command(MODE_MOVE, 8388607, 0, 1'b1));
		tick_run(3, 0);
		send(command(MODE_STOP, 0, 0, 1'b0));
		send(command(MODE_MOVE, -2, 0, 1'b0));
		tick_run(30, 20);
		send(command(MODE_HOME, 0, 0, 1'b1));
		send(command(MODE_HOME, 0, 0, 1'b0));
		tick_run(160, 150);
		send(command(MODE_HOME, 0, 1, 1'b0));
		tick_run(70, 60);
		tick_run(120, NO_TRIGGER);
		send(command(MODE_HOME, 0, 32'h7FFFFF, 1'b0));
		tick_run(10, 3);
		send(command(MODE_STOP, 0, 0, 1'b0));
		send(command(MODE_MOVE, -8388608, 0, 1'b0));
		send(command(MODE_STOP, 0, 0, 1'b0));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_config(50, 50, 1, 0, 1, 1, 0, 1);
				1: set_config(100001, 131071, 1048575, 1023, 0, 0, 1, 1);
				2: set_config(49, 0, 0, 1, 1, 1, 0, 0);
				default: set_config($urandom_range(0, 130), $urandom_range(0, 130),
					$urandom_range(0, 2),
					($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 60),
					$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
					($urandom_range(0, 5) != 0));
			endcase
			goal = sent_items + (ITEMS_TOTAL - sent_items) / (PHASES - p);
			do
				scenario();
			while (sent_items < goal);
		end

		drain(16);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/sphc_pkg.sv
hw/rtl/sphc_regs.sv
hw/rtl/sphc_core.sv
hw/rtl/stepper_pulse_homing_controller.sv
sim/stepper_pulse_homing_controller_check.sv
sim/stepper_pulse_homing_controller_tb.sv
